@@ src/fl2t_pkg.sv @@
// shared constants and the fraction rom for the fixed-point log2 table unit
// no dependencies; used by fl2t_norm and fixed_point_log2_table_unit
package fl2t_pkg;

  // operand width default and fixed field widths
  localparam int INPUT_WIDTH_DEF = 31;
  localparam int LOG_FRAC_BITS   = 15;
  localparam int MANT_BITS       = 8;
  localparam int IDX_WIDTH       = MANT_BITS - 1;
  localparam int ROM_DEPTH       = 1 << IDX_WIDTH;
  localparam int ROM_WIDTH       = 16;
  localparam int OUT_WIDTH       = 20;

  // control that travels with each request down the pipe
  typedef struct packed {
    logic valid;
    logic zero;
  } norm_ctl_t;

  // low 16 bits of signed q15 log2(m/256), m = 128..255
  localparam logic [ROM_WIDTH-1:0] FRAC_ROM [ROM_DEPTH] = '{
    16'h8000, 16'h8170, 16'h82DD, 16'h8448, 16'h85AF, 16'h8714, 16'h8876, 16'h89D6,
    16'h8B32, 16'h8C8D, 16'h8DE5, 16'h8F3A, 16'h908D, 16'h91DD, 16'h932B, 16'h9477,
    16'h95C1, 16'h9708, 16'h984D, 16'h998F, 16'h9AD0, 16'h9C0E, 16'h9D4A, 16'h9E85,
    16'h9FBD, 16'hA0F3, 16'hA227, 16'hA359, 16'hA489, 16'hA5B7, 16'hA6E3, 16'hA80D,
    16'hA935, 16'hAA5C, 16'hAB81, 16'hACA4, 16'hADC5, 16'hAEE4, 16'hB002, 16'hB11E,
    16'hB238, 16'hB351, 16'hB467, 16'hB57D, 16'hB690, 16'hB7A2, 16'hB8B3, 16'hB9C2,
    16'hBACF, 16'hBBDB, 16'hBCE5, 16'hBDEE, 16'hBEF6, 16'hBFFB, 16'hC100, 16'hC203,
    16'hC305, 16'hC405, 16'hC504, 16'hC601, 16'hC6FD, 16'hC7F8, 16'hC8F2, 16'hC9EA,
    16'hCAE1, 16'hCBD6, 16'hCCCA, 16'hCDBD, 16'hCEAF, 16'hCFA0, 16'hD08F, 16'hD17D,
    16'hD26A, 16'hD356, 16'hD441, 16'hD52A, 16'hD613, 16'hD6FA, 16'hD7E0, 16'hD8C5,
    16'hD9A9, 16'hDA8B, 16'hDB6D, 16'hDC4D, 16'hDD2D, 16'hDE0B, 16'hDEE9, 16'hDFC5,
    16'hE0A1, 16'hE17B, 16'hE254, 16'hE32D, 16'hE404, 16'hE4DA, 16'hE5B0, 16'hE684,
    16'hE758, 16'hE82A, 16'hE8FC, 16'hE9CD, 16'hEA9D, 16'hEB6C, 16'hEC3A, 16'hED07,
    16'hEDD3, 16'hEE9E, 16'hEF69, 16'hF032, 16'hF0FB, 16'hF1C3, 16'hF28A, 16'hF350,
    16'hF415, 16'hF4DA, 16'hF59E, 16'hF661, 16'hF723, 16'hF7E4, 16'hF8A5, 16'hF965,
    16'hFA24, 16'hFAE2, 16'hFB9F, 16'hFC5C, 16'hFD18, 16'hFDD3, 16'hFE8E, 16'hFF47
  };

endpackage

@@ src/fixed_point_log2_table_unit.sv @@
// top level: base-2 logarithm of an unsigned integer in q15 via a 128-entry rom
// depends on fl2t_pkg and fl2t_norm
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------
//  request | start, busy        | x_value [INPUT_WIDTH-1:0]
//  result  | done (one cycle)   | log2_q15 [19:0], zero_input
//
// three register stages: leading-one detect, normalising shift, rom and add
// one request can be taken every cycle; busy stays low
// reset clears the valid bits of all three stages, payload is not reset
// the result is held for one cycle only and cannot be stalled
module fixed_point_log2_table_unit #(
  parameter int INPUT_WIDTH = fl2t_pkg::INPUT_WIDTH_DEF,
  localparam int EW = $clog2(INPUT_WIDTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [INPUT_WIDTH-1:0]         x_value,
  output logic                           done,
  output logic [fl2t_pkg::OUT_WIDTH-1:0] log2_q15,
  output logic                           zero_input
);

  fl2t_pkg::norm_ctl_t               ctl;
  logic [EW-1:0]                     bit_len;
  logic [fl2t_pkg::IDX_WIDTH-1:0]    idx;
  logic [fl2t_pkg::ROM_WIDTH-1:0]    frac;
  logic [fl2t_pkg::OUT_WIDTH-1:0]    int_part;
  logic [fl2t_pkg::OUT_WIDTH-1:0]    frac_ext;
  logic [fl2t_pkg::OUT_WIDTH-1:0]    log2_q15_next;

  // fully pipelined, never refuses a request
  assign busy = 1'b0;

  // first two stages
  fl2t_norm #(
    .INPUT_WIDTH (INPUT_WIDTH)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .x        (x_value),
    .ctl      (ctl),
    .bit_len  (bit_len),
    .idx      (idx)
  );

  // rom lookup, sign-extend the fraction and add the integer part
  always_comb begin
    frac     = fl2t_pkg::FRAC_ROM[idx];
    int_part = fl2t_pkg::OUT_WIDTH'(bit_len) << fl2t_pkg::LOG_FRAC_BITS;
    frac_ext = {{(fl2t_pkg::OUT_WIDTH - fl2t_pkg::ROM_WIDTH){frac[fl2t_pkg::ROM_WIDTH-1]}},
                frac};
    if (ctl.zero) begin
      log2_q15_next = '0;
    end else begin
      log2_q15_next = int_part + frac_ext;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
    log2_q15   <= log2_q15_next;
    zero_input <= ctl.zero;
  end

`ifndef NO_ASSERTIONS
  // every result comes from a request taken through the two norm stages and the output register
  a_done_src: assert property (@(posedge clk)
    done |-> $past(start, 3))
    else $error("result without a request");

  // zero flag matches the operand of that request
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> zero_input == ($past(x_value, 3) == '0))
    else $error("zero flag does not match operand");

  // a zero operand gives a zero result
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    done && zero_input |-> log2_q15 == '0)
    else $error("zero operand gave a nonzero result");
`endif

endmodule

@@ src/fl2t_norm.sv @@
// leading-one detect and normalising shift, two register stages
// depends on fl2t_pkg
module fl2t_norm #(
  parameter int INPUT_WIDTH = fl2t_pkg::INPUT_WIDTH_DEF,
  localparam int EW = $clog2(INPUT_WIDTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [INPUT_WIDTH-1:0]         x,
  output fl2t_pkg::norm_ctl_t            ctl,
  output logic [EW-1:0]                  bit_len,
  output logic [fl2t_pkg::IDX_WIDTH-1:0] idx
);

  // stage one registers
  logic                   v1;
  logic                   z1;
  logic [EW-1:0]          e1;
  logic [INPUT_WIDTH-1:0] x1;
  logic [EW-1:0]          e1_next;

  // stage two registers
  logic                             v2;
  logic                             z2;
  logic [EW-1:0]                    e2;
  logic [fl2t_pkg::IDX_WIDTH-1:0]   idx2;
  logic [EW-1:0]                    shamt;
  logic [INPUT_WIDTH-1:0]           x_norm;

  // leading-one detect: bit length of the operand
  always_comb begin
    e1_next = '0;
    for (int i = 0; i < INPUT_WIDTH; i++) begin
      if (x[i]) begin
        e1_next = EW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    z1 <= (x == '0);
    e1 <= e1_next;
    x1 <= x;
  end

  // shift the leading one up to the top bit, short operands fill with zeros
  always_comb begin
    shamt  = EW'(INPUT_WIDTH) - e1;
    x_norm = x1 << shamt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    z2   <= z1;
    e2   <= e1;
    idx2 <= x_norm[INPUT_WIDTH-2 -: fl2t_pkg::IDX_WIDTH];
  end

  assign ctl.valid = v2;
  assign ctl.zero  = z2;
  assign bit_len   = e2;
  assign idx       = idx2;

`ifndef NO_ASSERTIONS
  // the detected length puts the leading one exactly at bit e-1
  a_lod_exact: assert property (@(posedge clk) disable iff (rst)
    v1 && !z1 |-> (x1 >> (e1 - EW'(1))) == INPUT_WIDTH'(1))
    else $error("leading-one position wrong");

  // a zero operand has zero length
  a_lod_zero: assert property (@(posedge clk) disable iff (rst)
    v1 |-> z1 == (e1 == '0))
    else $error("zero flag and length disagree");

  // stage two takes over the request of stage one in the cycle after
  a_stage_follow: assert property (@(posedge clk) disable iff (rst)
    v1 && !z1 |=> v2 && !z2 && e2 == $past(e1))
    else $error("stage two lost a request");
`endif

endmodule
